>>> design/skt_pkg.sv
`timescale 1ns / 1ps

package skt_pkg;

    localparam int KEY_W     = 8;
    localparam int CHILD_W   = 32;
    localparam int CMD_W     = 2;
    localparam int POS_W     = 4;
    localparam int STATUS_W  = 2;
    localparam int SLOT_W    = 4;
    localparam int COUNT_W   = 5;
    localparam int SHRINK_AT = 3;

    localparam logic [CMD_W-1:0] CMD_FIND   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_POS   = 2'd3;

    // Broadcast to every cell of the row for one update.
    typedef struct packed {
        logic insert;
        logic remove;
    } cell_ctl_t;

endpackage

>>> design/skt_if.sv
`timescale 1ns / 1ps

interface skt_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [skt_pkg::CMD_W-1:0]    command;
    logic [skt_pkg::KEY_W-1:0]    key;
    logic [skt_pkg::CHILD_W-1:0]  child_value;
    logic [skt_pkg::POS_W-1:0]    position;

    modport source (output valid, command, key, child_value, position, input ready);
    modport sink   (input valid, command, key, child_value, position, output ready);
endinterface

interface skt_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [skt_pkg::STATUS_W-1:0]  status;
    logic [skt_pkg::SLOT_W-1:0]    slot_index;
    logic [skt_pkg::CHILD_W-1:0]   found_child;
    logic [skt_pkg::COUNT_W-1:0]   entry_count;
    logic                          shrink_hint;
    logic [skt_pkg::CHILD_W-1:0]   first_child;
    logic [skt_pkg::CHILD_W-1:0]   last_child;

    modport source (output valid, status, slot_index, found_child, entry_count, shrink_hint,
                    first_child, last_child, input ready);
    modport sink   (input valid, status, slot_index, found_child, entry_count, shrink_hint,
                    first_child, last_child, output ready);
endinterface

>>> design/skt_cell.sv
`timescale 1ns / 1ps

module skt_cell #(
    parameter int CHILD_WIDTH = 32,
    parameter int IDX_W       = 4,
    parameter int SLOT        = 0
) (
    input  logic                            clk,
    input  skt_pkg::cell_ctl_t              ctl,
    input  logic [IDX_W-1:0]                at,
    input  logic [skt_pkg::KEY_W-1:0]       key_in,
    input  logic [CHILD_WIDTH-1:0]          child_in,
    input  logic [skt_pkg::KEY_W-1:0]       left_key,
    input  logic [CHILD_WIDTH-1:0]          left_child,
    input  logic [skt_pkg::KEY_W-1:0]       right_key,
    input  logic [CHILD_WIDTH-1:0]          right_child,
    output logic [skt_pkg::KEY_W-1:0]       key,
    output logic [CHILD_WIDTH-1:0]          child,
    output logic                            match,
    output logic                            greater
);

    localparam logic [IDX_W-1:0] MY_SLOT = IDX_W'(SLOT);

    logic [skt_pkg::KEY_W-1:0] key_reg, key_next;
    logic [CHILD_WIDTH-1:0]    child_reg, child_next;

    always_comb
    begin
        key_next   = key_reg;
        child_next = child_reg;
        if (ctl.insert)
        begin
            if (MY_SLOT == at)
            begin
                key_next   = key_in;
                child_next = child_in;
            end
            else if (MY_SLOT > at)
            begin
                key_next   = left_key;
                child_next = left_child;
            end
        end
        else if (ctl.remove && (MY_SLOT >= at))
        begin
            key_next   = right_key;
            child_next = right_child;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        child_reg <= child_next;
    end

    assign key     = key_reg;
    assign child   = child_reg;
    assign match   = (key_reg == key_in);
    assign greater = (key_in < key_reg);

endmodule

>>> design/sorted_byte_key_table.sv
`timescale 1ns / 1ps

// Sorted table of up to ENTRIES byte keys with a child value each, held in a row of cells
// in ascending unsigned key order. Find returns the lowest matching slot, insert places an
// entry after any equal keys and remove deletes by slot; every response also carries the
// entry count and the first and last child. The row compares and shifts in the cycle the
// command is accepted, the result waits in the pending registers, and the response is
// formed from the updated row when the output registers are free; a new command is not
// accepted while one is pending. A response held by the receiver does not stop the input at
// once: one further command is taken, and its response waits until the held one has gone.
module sorted_byte_key_table #(
    parameter int ENTRIES     = 16,
    parameter int CHILD_WIDTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    skt_cmd_if.sink    cmd,
    skt_rsp_if.source  rsp
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = CNT_W + skt_pkg::POS_W;

    logic [skt_pkg::KEY_W-1:0] cell_key   [ENTRIES];
    logic [CHILD_WIDTH-1:0]    cell_child [ENTRIES];
    logic [ENTRIES-1:0]        cell_match;
    logic [ENTRIES-1:0]        cell_greater;
    logic [ENTRIES-1:0]        cell_valid;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             pend_reg, pend_next;
    logic             out_valid_reg, out_valid_next;

    logic [skt_pkg::STATUS_W-1:0] pend_status_reg, pend_status_next;
    logic [skt_pkg::SLOT_W-1:0]   pend_slot_reg, pend_slot_next;
    logic [skt_pkg::CHILD_W-1:0]  pend_found_reg, pend_found_next;
    logic                         pend_hint_reg, pend_hint_next;

    logic [skt_pkg::STATUS_W-1:0] status_reg;
    logic [skt_pkg::SLOT_W-1:0]   slot_reg;
    logic [skt_pkg::CHILD_W-1:0]  found_reg;
    logic [skt_pkg::COUNT_W-1:0]  count_out_reg;
    logic                         hint_reg;
    logic [skt_pkg::CHILD_W-1:0]  first_reg;
    logic [skt_pkg::CHILD_W-1:0]  last_reg;

    logic                   accept;
    logic                   out_load;
    skt_pkg::cell_ctl_t     ctl;
    logic [IDX_W-1:0]       at;
    logic [CHILD_WIDTH-1:0] child_in;
    logic [IDX_W-1:0]       find_idx;
    logic                   find_hit;
    logic [IDX_W-1:0]       ins_idx;
    logic [IDX_W-1:0]       last_idx;

    assign child_in  = CHILD_WIDTH'(cmd.child_value);
    assign accept    = cmd.valid && cmd.ready;
    assign cmd.ready = !pend_reg;
    assign out_load  = pend_reg && (!out_valid_reg || rsp.ready);

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++)
        begin : g_row
            logic [skt_pkg::KEY_W-1:0] lk, rk;
            logic [CHILD_WIDTH-1:0]    lc, rc;

            if (g == 0)
            begin : g_first
                assign lk = cmd.key;
                assign lc = child_in;
            end
            else
            begin : g_mid_l
                assign lk = cell_key[g-1];
                assign lc = cell_child[g-1];
            end

            if (g == ENTRIES - 1)
            begin : g_last
                assign rk = cell_key[g];
                assign rc = cell_child[g];
            end
            else
            begin : g_mid_r
                assign rk = cell_key[g+1];
                assign rc = cell_child[g+1];
            end

            assign cell_valid[g] = (CNT_W'(g) < count_reg);

            skt_cell #(
                .CHILD_WIDTH (CHILD_WIDTH),
                .IDX_W       (IDX_W),
                .SLOT        (g)
            ) u_cell (
                .clk         (clk),
                .ctl         (ctl),
                .at          (at),
                .key_in      (cmd.key),
                .child_in    (child_in),
                .left_key    (lk),
                .left_child  (lc),
                .right_key   (rk),
                .right_child (rc),
                .key         (cell_key[g]),
                .child       (cell_child[g]),
                .match       (cell_match[g]),
                .greater     (cell_greater[g])
            );
        end
    endgenerate

    // Priority encoders: the lowest valid slot that matches, and the lowest valid slot holding
    // a greater key (the insertion point, or the count when there is none).
    always_comb
    begin
        find_idx = '0;
        find_hit = 1'b0;
        ins_idx  = IDX_W'(count_reg);
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (cell_match[i] && cell_valid[i])
            begin
                find_idx = IDX_W'(i);
                find_hit = 1'b1;
            end
            if (cell_greater[i] && cell_valid[i])
            begin
                ins_idx = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        ctl              = '0;
        at               = ins_idx;
        count_next       = count_reg;
        pend_status_next = pend_status_reg;
        pend_slot_next   = pend_slot_reg;
        pend_found_next  = pend_found_reg;
        pend_hint_next   = pend_hint_reg;
        if (accept)
        begin
            pend_status_next = skt_pkg::ST_OK;
            pend_slot_next   = '0;
            pend_found_next  = '0;
            pend_hint_next   = 1'b0;
            case (cmd.command)
                skt_pkg::CMD_FIND:
                begin
                    if (find_hit)
                    begin
                        pend_slot_next  = skt_pkg::SLOT_W'(find_idx);
                        pend_found_next = skt_pkg::CHILD_W'(cell_child[find_idx]);
                    end
                    else
                    begin
                        pend_status_next = skt_pkg::ST_NOT_FOUND;
                    end
                end
                skt_pkg::CMD_INSERT:
                begin
                    if (count_reg == CNT_W'(ENTRIES))
                    begin
                        pend_status_next = skt_pkg::ST_FULL;
                    end
                    else
                    begin
                        ctl.insert     = 1'b1;
                        count_next     = count_reg + 1'b1;
                        pend_slot_next = skt_pkg::SLOT_W'(ins_idx);
                    end
                end
                skt_pkg::CMD_REMOVE:
                begin
                    at = IDX_W'(cmd.position);
                    if (CMP_W'(cmd.position) >= CMP_W'(count_reg))
                    begin
                        pend_status_next = skt_pkg::ST_BAD_POS;
                    end
                    else
                    begin
                        ctl.remove     = 1'b1;
                        count_next     = count_reg - 1'b1;
                        pend_slot_next = skt_pkg::SLOT_W'(cmd.position);
                        pend_hint_next = (count_next == CNT_W'(skt_pkg::SHRINK_AT));
                    end
                end
                default:
                begin
                    pend_status_next = skt_pkg::ST_BAD_POS;
                end
            endcase
        end
    end

    assign last_idx = IDX_W'(count_reg - 1'b1);

    always_comb
    begin
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
            pend_next      = 1'b0;
        end
        if (accept)
        begin
            pend_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_status_reg <= pend_status_next;
        pend_slot_reg   <= pend_slot_next;
        pend_found_reg  <= pend_found_next;
        pend_hint_reg   <= pend_hint_next;
        // The row has already taken the update, so the ends are read from it directly.
        if (out_load)
        begin
            status_reg    <= pend_status_reg;
            slot_reg      <= pend_slot_reg;
            found_reg     <= pend_found_reg;
            hint_reg      <= pend_hint_reg;
            count_out_reg <= skt_pkg::COUNT_W'(count_reg);
            if (count_reg == '0)
            begin
                first_reg <= '0;
                last_reg  <= '0;
            end
            else
            begin
                first_reg <= skt_pkg::CHILD_W'(cell_child[0]);
                last_reg  <= skt_pkg::CHILD_W'(cell_child[last_idx]);
            end
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.slot_index  = slot_reg;
    assign rsp.found_child = found_reg;
    assign rsp.entry_count = count_out_reg;
    assign rsp.shrink_hint = hint_reg;
    assign rsp.first_child = first_reg;
    assign rsp.last_child  = last_reg;

endmodule
